// ===== hdl/mrrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrs_pkg
// Types, codes and the CRC-16 byte update shared by the holding-register
// slave.
// ----------------------------------------------------------------------------
package mrrs_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  FC_READ      = 8'h03;
    localparam logic [7:0]  FC_WRITE     = 8'h06;
    localparam logic [7:0]  EXC_FLAG     = 8'h80;
    localparam logic [7:0]  EXC_FUNCTION = 8'h01;
    localparam logic [7:0]  EXC_ADDRESS  = 8'h02;
    localparam logic [8:0]  LEN_SAT      = 9'd256;
    localparam logic [8:0]  MIN_FRAME    = 9'd8;
    localparam logic [2:0]  HDR_BYTES    = 3'd6;
    localparam logic [2:0]  EXC_BYTES    = 3'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HDR,
        S_RD_REQ,
        S_RD_HI,
        S_RD_LO,
        S_CRC_LO,
        S_CRC_HI
    } state_t;

    typedef enum logic [1:0] {
        MODE_READ,
        MODE_WRITE,
        MODE_EXC
    } mode_t;

    typedef struct packed {
        logic       push;
        logic       last;
        logic [7:0] data;
    } tx_push_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hdl/modbus_rtu_register_slave_top.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_top
// Modbus RTU slave for 16-bit holding registers: frame check, read and
// write of the register memory, and reply generation with its CRC.
// ----------------------------------------------------------------------------
// After reset the block zeroes its register memory, one entry a cycle, over
// all STORE_DEPTH entries, and takes no byte meanwhile. It then takes one
// request byte per cycle. On a byte that ends a frame with good length and
// CRC it takes no more until the reply is handed on: header bytes go out at
// one a cycle, each register read is requested on the memory's single read
// port before its two bytes go out, then the CRC, with waits while the
// output register is held. A reply leaves as groups of up to four bytes.
module modbus_rtu_register_slave_top #(
    parameter int STORE_DEPTH    = 128,
    parameter int MAX_READ_COUNT = 125
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] tx_byte_a,
    output logic [7:0] tx_byte_b,
    output logic [7:0] tx_byte_c,
    output logic [7:0] tx_byte_d,
    output logic [2:0] valid_bytes,
    output logic       reply_last
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [16:0] DEPTH_LIM = 17'(STORE_DEPTH);
    localparam logic [15:0] MAX_CNT   = 16'(MAX_READ_COUNT);
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);

    mrrs_pkg::state_t   state_reg, state_next;
    mrrs_pkg::mode_t    mode_reg, mode_next;
    mrrs_pkg::tx_push_t push;

    logic [7:0]    hdr_reg [6];
    logic [8:0]    len_reg;
    logic [15:0]   crc_reg;
    logic [15:0]   rcrc_reg;
    logic [7:0]    code_reg, code_next;
    logic [16:0]   addr_reg;
    logic [6:0]    left_reg;
    logic [2:0]    idx_reg;
    logic          oor_reg;
    logic [AW-1:0] clr_reg;

    logic          accept;
    logic [8:0]    len_next;
    logic [15:0]   crc_next;
    logic          frame_ok;
    logic          start;
    logic [15:0]   req_addr;
    logic [15:0]   req_val;
    logic          room;
    logic [2:0]    hdr_len;
    logic [7:0]    hdr_byte;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [15:0]   mem_rdata;
    logic [15:0]   rd_val;

    assign rx_stall = (state_reg != mrrs_pkg::S_IDLE);
    assign accept   = rx_valid && !rx_stall;
    assign len_next = (len_reg < mrrs_pkg::LEN_SAT) ? len_reg + 9'd1 : len_reg;
    assign crc_next = mrrs_pkg::crc_byte(crc_reg, rx_byte);
    assign frame_ok = (len_next >= mrrs_pkg::MIN_FRAME) && (crc_next == 16'h0);
    assign start    = accept && frame_end && frame_ok;
    assign req_addr = {hdr_reg[2], hdr_reg[3]};
    assign req_val  = {hdr_reg[4], hdr_reg[5]};
    assign hdr_len  = (mode_reg == mrrs_pkg::MODE_WRITE) ? mrrs_pkg::HDR_BYTES
                                                         : mrrs_pkg::EXC_BYTES;
    assign rd_val   = oor_reg ? 16'h0 : mem_rdata;

    always_comb
    begin
        mode_next = mrrs_pkg::MODE_EXC;
        code_next = mrrs_pkg::EXC_FUNCTION;
        if (hdr_reg[1] == mrrs_pkg::FC_READ)
        begin
            if (req_val > MAX_CNT)
            begin
                code_next = mrrs_pkg::EXC_ADDRESS;
            end
            else
            begin
                mode_next = mrrs_pkg::MODE_READ;
            end
        end
        else if (hdr_reg[1] == mrrs_pkg::FC_WRITE)
        begin
            if ({1'b0, req_addr} < DEPTH_LIM)
            begin
                mode_next = mrrs_pkg::MODE_WRITE;
            end
            else
            begin
                code_next = mrrs_pkg::EXC_ADDRESS;
            end
        end
    end

    always_comb
    begin
        hdr_byte = hdr_reg[0];
        unique case (mode_reg)
            mrrs_pkg::MODE_READ:
            begin
                case (idx_reg)
                    3'd0: hdr_byte = hdr_reg[0];
                    3'd1: hdr_byte = mrrs_pkg::FC_READ;
                    default: hdr_byte = {left_reg, 1'b0};
                endcase
            end
            mrrs_pkg::MODE_WRITE:
            begin
                hdr_byte = (idx_reg < mrrs_pkg::HDR_BYTES) ? hdr_reg[idx_reg] : 8'h0;
            end
            default:
            begin
                case (idx_reg)
                    3'd0: hdr_byte = hdr_reg[0];
                    3'd1: hdr_byte = hdr_reg[1] | mrrs_pkg::EXC_FLAG;
                    default: hdr_byte = code_reg;
                endcase
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrrs_pkg::S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                    state_next = mrrs_pkg::S_IDLE;
            end
            mrrs_pkg::S_IDLE:
            begin
                if (start)
                    state_next = mrrs_pkg::S_HDR;
            end
            mrrs_pkg::S_HDR:
            begin
                if (room && idx_reg == hdr_len - 3'd1)
                begin
                    if (mode_reg == mrrs_pkg::MODE_READ && left_reg != 7'd0)
                        state_next = mrrs_pkg::S_RD_REQ;
                    else
                        state_next = mrrs_pkg::S_CRC_LO;
                end
            end
            mrrs_pkg::S_RD_REQ:
            begin
                state_next = mrrs_pkg::S_RD_HI;
            end
            mrrs_pkg::S_RD_HI:
            begin
                if (room)
                    state_next = mrrs_pkg::S_RD_LO;
            end
            mrrs_pkg::S_RD_LO:
            begin
                if (room)
                    state_next = (left_reg == 7'd1) ? mrrs_pkg::S_CRC_LO
                                                    : mrrs_pkg::S_RD_REQ;
            end
            mrrs_pkg::S_CRC_LO:
            begin
                if (room)
                    state_next = mrrs_pkg::S_CRC_HI;
            end
            mrrs_pkg::S_CRC_HI:
            begin
                if (room)
                    state_next = mrrs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mrrs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push      = '0;
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = 16'h0;
        mem_re    = 1'b0;
        unique case (state_reg)
            mrrs_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            mrrs_pkg::S_IDLE:
            begin
                mem_we    = start && (mode_next == mrrs_pkg::MODE_WRITE);
                mem_waddr = req_addr[AW-1:0];
                mem_wdata = req_val;
            end
            mrrs_pkg::S_HDR:
            begin
                push.push = room;
                push.data = hdr_byte;
            end
            mrrs_pkg::S_RD_REQ:
            begin
                mem_re = 1'b1;
            end
            mrrs_pkg::S_RD_HI:
            begin
                push.push = room;
                push.data = rd_val[15:8];
            end
            mrrs_pkg::S_RD_LO:
            begin
                push.push = room;
                push.data = rd_val[7:0];
            end
            mrrs_pkg::S_CRC_LO:
            begin
                push.push = room;
                push.data = rcrc_reg[7:0];
            end
            mrrs_pkg::S_CRC_HI:
            begin
                push.push = room;
                push.last = 1'b1;
                push.data = rcrc_reg[15:8];
            end
            default:
            begin
                push = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrrs_pkg::S_CLEAR;
            clr_reg   <= '0;
            len_reg   <= 9'd0;
            crc_reg   <= mrrs_pkg::CRC_INIT;
            for (int i = 0; i < 6; i++)
                hdr_reg[i] <= 8'h0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mrrs_pkg::S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (accept)
            begin
                if (len_reg < 9'(mrrs_pkg::HDR_BYTES))
                    hdr_reg[len_reg[2:0]] <= rx_byte;
                len_reg <= frame_end ? 9'd0 : len_next;
                crc_reg <= frame_end ? mrrs_pkg::CRC_INIT : crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode_next;
            code_reg <= code_next;
            addr_reg <= {1'b0, req_addr};
            left_reg <= req_val[6:0];
            idx_reg  <= 3'd0;
            rcrc_reg <= mrrs_pkg::CRC_INIT;
        end
        if (state_reg == mrrs_pkg::S_RD_REQ)
            oor_reg <= !(addr_reg < DEPTH_LIM);
        if (push.push && state_reg != mrrs_pkg::S_CRC_LO && state_reg != mrrs_pkg::S_CRC_HI)
            rcrc_reg <= mrrs_pkg::crc_byte(rcrc_reg, push.data);
        if (push.push && state_reg == mrrs_pkg::S_HDR)
            idx_reg <= idx_reg + 3'd1;
        if (push.push && state_reg == mrrs_pkg::S_RD_LO)
        begin
            addr_reg <= addr_reg + 17'd1;
            left_reg <= left_reg - 7'd1;
        end
    end

    mrrs_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    mrrs_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_in     (push),
        .room        (room),
        .tx_valid    (tx_valid),
        .tx_stall    (tx_stall),
        .tx_byte_a   (tx_byte_a),
        .tx_byte_b   (tx_byte_b),
        .tx_byte_c   (tx_byte_c),
        .tx_byte_d   (tx_byte_d),
        .valid_bytes (valid_bytes),
        .reply_last  (reply_last)
    );

`ifndef SYNTHESIS
    a_clear_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mrrs_pkg::S_CLEAR |-> rx_stall)
        else $error("Byte taken during the memory clearing pass.");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> room)
        else $error("Reply byte pushed while the output register is held.");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == mrrs_pkg::S_CLEAR || state_reg == mrrs_pkg::S_IDLE))
        else $error("Register memory written during a reply.");

    a_group_count: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> (valid_bytes != 3'd0 && valid_bytes <= 3'd4))
        else $error("Output group carries an impossible byte count.");

    a_read_then_byte: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mrrs_pkg::S_RD_REQ |=> state_reg == mrrs_pkg::S_RD_HI)
        else $error("Register read not followed by its high byte.");
`endif

endmodule

// ===== hdl/mrrs_store.sv =====
// ----------------------------------------------------------------------------
// mrrs_store
// Holding-register memory: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mrrs_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mrrs_pack.sv =====
// ----------------------------------------------------------------------------
// mrrs_pack
// Gathers reply bytes into groups of up to four and holds each group in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module mrrs_pack (
    input  logic               clk,
    input  logic               rst_n,
    input  mrrs_pkg::tx_push_t push_in,
    output logic               room,
    output logic               tx_valid,
    input  logic               tx_stall,
    output logic [7:0]         tx_byte_a,
    output logic [7:0]         tx_byte_b,
    output logic [7:0]         tx_byte_c,
    output logic [7:0]         tx_byte_d,
    output logic [2:0]         valid_bytes,
    output logic               reply_last
);

    logic [7:0]  acc_reg [3];
    logic [1:0]  acc_cnt_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [2:0]  out_cnt_reg;
    logic        out_last_reg;
    logic        load;
    logic [31:0] group;

    assign room = !out_valid_reg || !tx_stall;
    assign load = push_in.push && (push_in.last || acc_cnt_reg == 2'd3);

    always_comb
    begin
        group = 32'h0;
        case (acc_cnt_reg)
            2'd0: group = {push_in.data, 24'h0};
            2'd1: group = {acc_reg[0], push_in.data, 16'h0};
            2'd2: group = {acc_reg[0], acc_reg[1], push_in.data, 8'h0};
            default: group = {acc_reg[0], acc_reg[1], acc_reg[2], push_in.data};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                acc_cnt_reg   <= 2'd0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (push_in.push)
                begin
                    acc_cnt_reg <= acc_cnt_reg + 2'd1;
                end
                if (!tx_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push && !load)
        begin
            acc_reg[acc_cnt_reg] <= push_in.data;
        end
        if (load)
        begin
            out_data_reg <= group;
            out_cnt_reg  <= {1'b0, acc_cnt_reg} + 3'd1;
            out_last_reg <= push_in.last;
        end
    end

    assign tx_valid    = out_valid_reg;
    assign tx_byte_a   = out_data_reg[31:24];
    assign tx_byte_b   = out_data_reg[23:16];
    assign tx_byte_c   = out_data_reg[15:8];
    assign tx_byte_d   = out_data_reg[7:0];
    assign valid_bytes = out_cnt_reg;
    assign reply_last  = out_last_reg;

endmodule
